>>> hw/rtl/rgp_pkg.sv
// ----------------------------------------------------------------------------
// rgp_pkg
// Shared types and constants of the rank group prune block.
// ----------------------------------------------------------------------------
`default_nettype none

package rgp_pkg;

  localparam int unsigned MaxItems = 32;
  localparam int unsigned HandleW  = 16;
  localparam int unsigned RankW    = 32;
  localparam int unsigned PosW     = 5;
  localparam int unsigned TakeW    = 6;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DEDUP,
    ST_SORT_SCAN,
    ST_SORT_SWAP,
    ST_PART_INIT,
    ST_PART_STEP,
    ST_PART_DONE,
    ST_EMIT
  } rgp_state_e;

  // Controller to datapath
  typedef struct packed {
    logic store_item;   // write input item into the stores, start dedup
    logic dedup_step;   // compare one distinct entry
    logic dedup_add;    // append rank to distinct list
    logic sort_init;    // i = 0
    logic sort_scan;    // one compare of the selection scan
    logic sort_swap;    // swap distinct[i] and distinct[best], advance i
    logic part_init;    // load left/right for group g
    logic part_step;    // one pointer move or swap
    logic part_done;    // front = left, advance g
    logic emit_init;    // k = 0
    logic emit_step;    // advance k
    logic clear;        // reset counts after the list
  } rgp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;         // item store full
    logic dedup_end;    // scan finished
    logic dedup_hit;    // current entry matches
    logic sort_done;    // i reached distinct_count
    logic scan_end;     // scan index past end
    logic part_end;     // left > right
    logic stop;         // front >= minimum_take after group
    logic groups_end;   // last group processed
    logic emit_last;    // k is the final item
    logic empty;        // no items stored
  } rgp_sts_t;

endpackage : rgp_pkg

`default_nettype wire

>>> hw/rtl/rank_group_prune.sv
// ----------------------------------------------------------------------------
// rank_group_prune
// Loads a list of handle/rank items, partitions it by rank group from the
// highest rank down, then streams the reordered list out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready/tlast   tdata = handle, rank
//  m_axis    out  tvalid/tready/tlast   tdata = handle, rank, pos, take, ovf
//  cfg       in   cfg_we_i              cfg_wdata_i = minimum_take
//
//  Load: each stored item takes one dedup compare per distinct rank until a
//  match; an item dropped beyond capacity skips dedup.
//  After last: selection sort of the distinct ranks, then one pointer move
//  per cycle per group pass, then one result per cycle while m_axis is ready.
//  No input is taken while a list is sorted, partitioned or emitted.
//  Reset clears counts and state; the stores need no clearing.
`default_nettype none

module rank_group_prune import rgp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // [15:0] item_handle, [47:16] rank
  input  wire logic        s_axis_tlast,   // last
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [15:0] out_handle, [47:16] out_rank, [52:48] position,
  // [58:53] take_count, [59] overflow, [63:60] zero
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast,   // end_of_list
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i
);

  rgp_cmd_t cmd;
  rgp_sts_t sts;
  logic [TakeW-1:0] min_take_q;
  logic [HandleW-1:0] oh;
  logic [RankW-1:0] orank;
  logic [PosW-1:0] pos;
  logic [TakeW-1:0] take;
  logic ovf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_take_q <= '0;
    end else if (cfg_we_i) begin
      min_take_q <= cfg_wdata_i;
    end
  end

  rgp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rgp_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_handle_i  (s_axis_tdata[15:0]),
    .in_rank_i    (s_axis_tdata[47:16]),
    .min_take_i   (min_take_q),
    .out_handle_o (oh),
    .out_rank_o   (orank),
    .position_o   (pos),
    .take_count_o (take),
    .overflow_o   (ovf)
  );

  assign m_axis_tdata = {4'b0, ovf, take, pos, orank, oh};

endmodule : rank_group_prune

`default_nettype wire

>>> hw/rtl/rgp_datapath.sv
// ----------------------------------------------------------------------------
// rgp_datapath
// Item and rank stores, distinct-rank list, sort and partition pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module rgp_datapath import rgp_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rgp_cmd_t           cmd_i,
  output rgp_sts_t                sts_o,
  input  wire logic [HandleW-1:0] in_handle_i,
  input  wire logic [RankW-1:0]   in_rank_i,
  input  wire logic [TakeW-1:0]   min_take_i,
  output logic [HandleW-1:0]      out_handle_o,
  output logic [RankW-1:0]        out_rank_o,
  output logic [PosW-1:0]         position_o,
  output logic [TakeW-1:0]        take_count_o,
  output logic                    overflow_o
);

  localparam int unsigned IdxW = $clog2(MaxItems);
  localparam int unsigned CntW = $clog2(MaxItems + 1);
  localparam int unsigned PtrW = CntW + 1; // signed pointer, right may reach -1

  logic [HandleW-1:0] hstore_q [MaxItems];
  logic [RankW-1:0]   rstore_q [MaxItems];
  logic [RankW-1:0]   dist_q   [MaxItems];

  logic [CntW-1:0] item_cnt_q, dist_cnt_q;
  logic            ovf_q;
  logic [RankW-1:0] new_rank_q;
  logic [CntW-1:0] n_q;      // dedup / scan index
  logic [CntW-1:0] i_q, best_q, g_q, k_q;
  logic signed [PtrW-1:0] left_q, right_q;
  logic [CntW-1:0] front_q;
  logic [RankW-1:0] cur_q;

  logic [IdxW-1:0] lidx, ridx;
  logic [RankW-1:0] rl, rr;
  logic l_hit, r_hit, lr_ok;

  assign lidx  = left_q[IdxW-1:0];
  assign ridx  = right_q[IdxW-1:0];
  assign rl    = rstore_q[lidx];
  assign rr    = rstore_q[ridx];
  assign l_hit = (rl == cur_q);
  assign r_hit = (rr == cur_q);
  assign lr_ok = (left_q <= right_q);

  always_comb begin
    sts_o            = '0;
    sts_o.full       = (item_cnt_q == CntW'(MaxItems));
    sts_o.dedup_end  = (n_q >= dist_cnt_q);
    sts_o.dedup_hit  = (n_q < dist_cnt_q) && (dist_q[n_q[IdxW-1:0]] == new_rank_q);
    sts_o.sort_done  = (i_q >= dist_cnt_q);
    sts_o.scan_end   = (n_q >= dist_cnt_q);
    sts_o.part_end   = !lr_ok;
    sts_o.stop       = (front_q >= CntW'(min_take_i));
    sts_o.groups_end = (g_q >= dist_cnt_q);
    sts_o.emit_last  = (k_q + CntW'(1) >= item_cnt_q);
    sts_o.empty      = (item_cnt_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_cnt_q <= '0;
      dist_cnt_q <= '0;
      ovf_q      <= 1'b0;
      n_q        <= '0;
      i_q        <= '0;
      best_q     <= '0;
      g_q        <= '0;
      k_q        <= '0;
      left_q     <= '0;
      right_q    <= '0;
      front_q    <= '0;
    end else begin
      if (cmd_i.store_item) begin
        if (item_cnt_q == CntW'(MaxItems)) begin
          ovf_q <= 1'b1;
        end else begin
          item_cnt_q <= item_cnt_q + CntW'(1);
        end
        n_q <= '0;
      end
      if (cmd_i.dedup_step) begin
        n_q <= n_q + CntW'(1);
      end
      if (cmd_i.dedup_add) begin
        dist_cnt_q <= dist_cnt_q + CntW'(1);
      end
      if (cmd_i.sort_init) begin
        i_q    <= '0;
        best_q <= '0;
        n_q    <= CntW'(1);
      end
      if (cmd_i.sort_scan) begin
        if (dist_q[n_q[IdxW-1:0]] > dist_q[best_q[IdxW-1:0]]) begin
          best_q <= n_q;
        end
        n_q <= n_q + CntW'(1);
      end
      if (cmd_i.sort_swap) begin
        i_q    <= i_q + CntW'(1);
        best_q <= i_q + CntW'(1);
        n_q    <= i_q + CntW'(2);
      end
      if (cmd_i.part_init) begin
        left_q  <= PtrW'(front_q);
        right_q <= PtrW'(item_cnt_q) - PtrW'(1);
      end
      if (cmd_i.part_step) begin
        // one move per cycle: skip left, skip right, or swap both
        if (l_hit) begin
          left_q <= left_q + PtrW'(1);
        end else if (!r_hit) begin
          right_q <= right_q - PtrW'(1);
        end else begin
          if (left_q < right_q) begin
            left_q <= left_q + PtrW'(1);
          end
          right_q <= right_q - PtrW'(1);
        end
      end
      if (cmd_i.part_done) begin
        front_q <= left_q[CntW-1:0];
        g_q     <= g_q + CntW'(1);
      end
      if (cmd_i.sort_init) begin
        g_q     <= '0;
        front_q <= '0;
      end
      if (cmd_i.emit_init) begin
        k_q <= '0;
      end
      if (cmd_i.emit_step) begin
        k_q <= k_q + CntW'(1);
      end
      if (cmd_i.clear) begin
        item_cnt_q <= '0;
        dist_cnt_q <= '0;
        ovf_q      <= 1'b0;
      end
    end
  end

  // stores, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_item) begin
      new_rank_q <= in_rank_i;
      if (item_cnt_q != CntW'(MaxItems)) begin
        hstore_q[item_cnt_q[IdxW-1:0]] <= in_handle_i;
        rstore_q[item_cnt_q[IdxW-1:0]] <= in_rank_i;
      end
    end
    if (cmd_i.dedup_add) begin
      dist_q[dist_cnt_q[IdxW-1:0]] <= new_rank_q;
    end
    if (cmd_i.sort_swap) begin
      dist_q[i_q[IdxW-1:0]]    <= dist_q[best_q[IdxW-1:0]];
      dist_q[best_q[IdxW-1:0]] <= dist_q[i_q[IdxW-1:0]];
    end
    if (cmd_i.part_init) begin
      cur_q <= dist_q[g_q[IdxW-1:0]];
    end
    if (cmd_i.part_step && !l_hit && r_hit && (left_q < right_q)) begin
      hstore_q[lidx] <= hstore_q[ridx];
      rstore_q[lidx] <= rr;
      hstore_q[ridx] <= hstore_q[lidx];
      rstore_q[ridx] <= rl;
    end
  end

  assign out_handle_o = hstore_q[k_q[IdxW-1:0]];
  assign out_rank_o   = rstore_q[k_q[IdxW-1:0]];
  assign position_o   = PosW'(k_q);
  assign take_count_o = TakeW'(front_q);
  assign overflow_o   = ovf_q;

endmodule : rgp_datapath

`default_nettype wire

>>> hw/rtl/rgp_ctrl.sv
// ----------------------------------------------------------------------------
// rgp_ctrl
// Sequencer for load, dedup, selection sort, partition and emit phases.
// ----------------------------------------------------------------------------
`default_nettype none

module rgp_ctrl import rgp_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output logic          out_last_o,
  output rgp_cmd_t      cmd_o,
  input  wire rgp_sts_t sts_i
);

  rgp_state_e state_q, state_d;
  logic last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_last_o  = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store_item = 1'b1;
          last_d           = in_last_i;
          // dropped item skips dedup
          state_d = sts_i.full ? (in_last_i ? ST_SORT_SCAN : ST_LOAD) : ST_DEDUP;
          if (sts_i.full && in_last_i) begin
            cmd_o.sort_init = 1'b1;
          end
        end
      end
      ST_DEDUP: begin
        if (sts_i.dedup_hit || sts_i.dedup_end) begin
          cmd_o.dedup_add = !sts_i.dedup_hit;
          if (last_q) begin
            cmd_o.sort_init = 1'b1;
            state_d         = ST_SORT_SCAN;
          end else begin
            state_d = ST_LOAD;
          end
        end else begin
          cmd_o.dedup_step = 1'b1;
        end
      end
      ST_SORT_SCAN: begin
        if (sts_i.sort_done) begin
          state_d = ST_PART_INIT;
        end else if (sts_i.scan_end) begin
          state_d = ST_SORT_SWAP;
        end else begin
          cmd_o.sort_scan = 1'b1;
        end
      end
      ST_SORT_SWAP: begin
        cmd_o.sort_swap = 1'b1;
        state_d         = ST_SORT_SCAN;
      end
      ST_PART_INIT: begin
        if (sts_i.groups_end) begin
          cmd_o.emit_init = 1'b1;
          state_d         = sts_i.empty ? ST_LOAD : ST_EMIT;
          cmd_o.clear     = sts_i.empty;
        end else begin
          cmd_o.part_init = 1'b1;
          state_d         = ST_PART_STEP;
        end
      end
      ST_PART_STEP: begin
        if (sts_i.part_end) begin
          cmd_o.part_done = 1'b1;
          state_d         = ST_PART_DONE;
        end else begin
          cmd_o.part_step = 1'b1;
        end
      end
      ST_PART_DONE: begin
        if (sts_i.stop || sts_i.groups_end) begin
          cmd_o.emit_init = 1'b1;
          state_d         = sts_i.empty ? ST_LOAD : ST_EMIT;
          cmd_o.clear     = sts_i.empty;
        end else begin
          state_d = ST_PART_INIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        out_last_o  = sts_i.emit_last;
        if (out_ready_i) begin
          if (sts_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            cmd_o.emit_step = 1'b1;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule : rgp_ctrl

`default_nettype wire
